FILE: rtl/cfu_pkg.sv
`default_nettype none

package cfu_pkg;

  localparam int FRAME_BYTES  = 8;
  localparam int ID_W         = 11;
  localparam int SLOT_W       = 5;
  localparam int FIELD_W      = 4;
  localparam int VALUE_W      = 32;
  localparam int APB_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Relative identifiers: slots 0..16 sit at 0x00..0x10, the response slot at 0x22.
  localparam logic [ID_W-1:0]   REL_ID_LAST_DENSE = ID_W'(8'h10);
  localparam logic [ID_W-1:0]   REL_ID_RESPONSE   = ID_W'(8'h22);
  localparam logic [SLOT_W-1:0] SLOT_ANALOG   = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_BYTES    = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_STATUS   = SLOT_W'(10);
  localparam logic [SLOT_W-1:0] SLOT_TIMER    = SLOT_W'(12);
  localparam logic [SLOT_W-1:0] SLOT_DIAG     = SLOT_W'(15);
  localparam logic [SLOT_W-1:0] SLOT_RESPONSE = SLOT_W'(17);
  localparam logic [FIELD_W-1:0] FIELD_MAX    = FIELD_W'(10);

  localparam logic [7:0] STATUS_MODE_MASK = 8'hE0;

  // Register index decoded from paddr.
  localparam logic [CFG_ADDR_W-3:0] REG_ID_OFFSET = '0;

  typedef enum logic [2:0] {
    KIND_WORDS,
    KIND_BYTES,
    KIND_TIMER,
    KIND_RESP,
    KIND_ANALOG,
    KIND_STATUS,
    KIND_DIAG
  } kind_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_data_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    kind_t             kind;
    frame_data_t       data;
  } job_t;

  function automatic kind_t slot_kind(logic [SLOT_W-1:0] slot);
    kind_t k;
    priority if (slot == SLOT_ANALOG) begin
      k = KIND_ANALOG;
    end else if (slot == SLOT_BYTES) begin
      k = KIND_BYTES;
    end else if (slot == SLOT_STATUS) begin
      k = KIND_STATUS;
    end else if (slot == SLOT_TIMER) begin
      k = KIND_TIMER;
    end else if (slot == SLOT_DIAG) begin
      k = KIND_DIAG;
    end else if (slot == SLOT_RESPONSE) begin
      k = KIND_RESP;
    end else begin
      k = KIND_WORDS;
    end
    return k;
  endfunction

  function automatic logic [FIELD_W-1:0] field_count(kind_t k);
    logic [FIELD_W-1:0] n;
    unique case (k)
      KIND_WORDS:  n = FIELD_W'(4);
      KIND_BYTES:  n = FIELD_W'(8);
      KIND_TIMER:  n = FIELD_W'(3);
      KIND_RESP:   n = FIELD_W'(3);
      KIND_ANALOG: n = FIELD_W'(6);
      KIND_STATUS: n = FIELD_W'(11);
      KIND_DIAG:   n = FIELD_W'(2);
      default:     n = FIELD_W'(1);
    endcase
    return n;
  endfunction

  function automatic logic [VALUE_W-1:0] field_value(kind_t k, logic [FIELD_W-1:0] f,
                                                     frame_data_t d);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [VALUE_W-1:0] v;
    w0 = {d[3], d[2], d[1], d[0]};
    w1 = {d[7], d[6], d[5], d[4]};
    v  = '0;
    unique case (k)
      KIND_WORDS: v = {16'b0, d[{f[1:0], 1'b1}], d[{f[1:0], 1'b0}]};
      KIND_BYTES: v = {24'b0, d[f[2:0]]};
      KIND_TIMER: begin
        priority case (f)
          FIELD_W'(0): v = {16'b0, d[1], d[0]};
          FIELD_W'(1): v = {16'b0, d[3], d[2]};
          default:     v = w1;
        endcase
      end
      KIND_RESP: begin
        priority case (f)
          FIELD_W'(0): v = {16'b0, d[1], d[0]};
          FIELD_W'(1): v = {24'b0, d[2]};
          default:     v = {16'b0, d[5], d[4]};
        endcase
      end
      KIND_ANALOG: begin
        // Each 32-bit little-endian word carries three 10-bit readings.
        priority case (f)
          FIELD_W'(0): v = {22'b0, w0[9:0]};
          FIELD_W'(1): v = {22'b0, w0[19:10]};
          FIELD_W'(2): v = {22'b0, w0[29:20]};
          FIELD_W'(3): v = {22'b0, w1[9:0]};
          FIELD_W'(4): v = {22'b0, w1[19:10]};
          default:     v = {22'b0, w1[29:20]};
        endcase
      end
      KIND_STATUS: begin
        priority case (f)
          FIELD_W'(0):  v = {16'b0, d[1], d[0]};
          FIELD_W'(1):  v = {24'b0, d[2]};
          FIELD_W'(2):  v = {24'b0, d[3]};
          FIELD_W'(3):  v = {31'b0, d[4][0]};
          FIELD_W'(4):  v = {24'b0, (d[4] & STATUS_MODE_MASK)} >> 5;
          FIELD_W'(5):  v = {24'b0, d[5]};
          FIELD_W'(6):  v = {31'b0, d[6][0]};
          FIELD_W'(7):  v = {31'b0, d[6][7]};
          FIELD_W'(8):  v = {31'b0, d[7][0]};
          FIELD_W'(9):  v = {31'b0, d[7][1]};
          default:      v = {31'b0, d[7][2]};
        endcase
      end
      KIND_DIAG: v = f[0] ? {d[4], d[5], d[6], d[7]} : {d[0], d[1], d[2], d[3]};
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfu_if.sv
`default_nettype none

interface cfu_in_if;
  import cfu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   frame_id;
  logic [7:0]        byte0;
  logic [7:0]        byte1;
  logic [7:0]        byte2;
  logic [7:0]        byte3;
  logic [7:0]        byte4;
  logic [7:0]        byte5;
  logic [7:0]        byte6;
  logic [7:0]        byte7;

  modport source (output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                  byte6, byte7, input ready);
  modport sink   (input valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                  byte6, byte7, output ready);
endinterface

interface cfu_out_if;
  import cfu_pkg::*;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  message_slot;
  logic [FIELD_W-1:0] field_number;
  logic [VALUE_W-1:0] signal_value;
  logic               last_field;

  modport source (output valid, message_slot, field_number, signal_value, last_field,
                  input ready);
  modport sink   (input valid, message_slot, field_number, signal_value, last_field,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/cfu_front.sv
`default_nettype none

module cfu_front (
  cfu_in_if.sink                    in_ch,
  input  wire logic [cfu_pkg::ID_W-1:0] id_offset,
  input  wire logic                 queue_full,
  output logic                      push,
  output cfu_pkg::job_t             push_job
);
  import cfu_pkg::*;

  logic [ID_W:0]     rel;
  logic [ID_W-1:0]   rel_id;
  logic              hit;
  logic [SLOT_W-1:0] slot;

  // The frame id minus the offset gives the relative id; a borrow means no slot.
  assign rel    = {1'b0, in_ch.frame_id} - {1'b0, id_offset};
  assign rel_id = rel[ID_W-1:0];
  assign hit    = !rel[ID_W] && ((rel_id <= REL_ID_LAST_DENSE) || (rel_id == REL_ID_RESPONSE));
  assign slot   = (rel_id == REL_ID_RESPONSE) ? SLOT_RESPONSE : rel_id[SLOT_W-1:0];

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full && hit;

  assign push_job.slot = slot;
  assign push_job.kind = slot_kind(slot);
  assign push_job.data = {in_ch.byte7, in_ch.byte6, in_ch.byte5, in_ch.byte4,
                          in_ch.byte3, in_ch.byte2, in_ch.byte1, in_ch.byte0};

endmodule

`default_nettype wire

FILE: rtl/cfu_fifo.sv
`default_nettype none

module cfu_fifo #(
  parameter int DEPTH = cfu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  cfu_pkg::job_t      push_job,
  output logic               full,
  input  wire logic          pop,
  output cfu_pkg::job_t      head_job,
  output logic               empty
);
  import cfu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfu_back.sv
`default_nettype none

module cfu_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  cfu_pkg::job_t head_job,
  input  wire logic     empty,
  output logic          pop,
  cfu_out_if.source     out_ch
);
  import cfu_pkg::*;

  logic [FIELD_W-1:0] field_r, field_nxt;
  logic               valid_r, valid_nxt;
  logic [SLOT_W-1:0]  slot_r;
  logic [FIELD_W-1:0] number_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;
  logic               load;
  logic               is_last;

  assign load    = !empty && (!valid_r || out_ch.ready);
  assign is_last = (field_r == field_count(head_job.kind) - 1'b1);
  assign pop     = load && is_last;

  always_comb begin
    field_nxt = field_r;
    valid_nxt = valid_r;
    if (load) begin
      field_nxt = is_last ? '0 : field_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
      valid_r <= 1'b0;
    end else begin
      field_r <= field_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r   <= head_job.slot;
      number_r <= field_r;
      value_r  <= field_value(head_job.kind, field_r, head_job.data);
      last_r   <= is_last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.message_slot = slot_r;
  assign out_ch.field_number = number_r;
  assign out_ch.signal_value = value_r;
  assign out_ch.last_field   = last_r;

endmodule

`default_nettype wire

FILE: rtl/can_frame_signal_unpacker.sv
// Channel  | Direction | Word contents
// ---------+-----------+---------------------------------------------------------
// in_ch    | sink      | frame_id[10:0], byte0..byte7 (one received CAN frame)
// out_ch   | source    | message_slot[4:0], field_number[3:0], signal_value[31:0],
//          |           | last_field (one decoded signal)
// cfg APB  | slave     | register 0 at byte address 0: id_offset[10:0]
//
// A frame is taken when the frame queue has room; the identifier match happens on the
// way in, so a frame with an unknown identifier is taken and dropped there.
// A matched frame then yields one result word per cycle while out_ch is ready, 2 to 11
// words depending on its message, paced by the single field counter in the output stage.
// Up to QUEUE_DEPTH matched frames wait in the queue, so input and output stall apart.
// Reset is synchronous and active low; it clears the offset, the queue and the output.
`default_nettype none

module can_frame_signal_unpacker #(
  parameter int QUEUE_DEPTH = cfu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cfu_in_if.sink                              in_ch,
  cfu_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cfu_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cfu_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [cfu_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import cfu_pkg::*;

  logic [ID_W-1:0]        id_offset_r, id_offset_nxt;
  logic [CFG_ADDR_W-3:0]  reg_index;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  job_t                   push_job;
  job_t                   head_job;

  // The register file has a single entry; writes to other indexes are dropped.
  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign prdata    = (reg_index == REG_ID_OFFSET) ?
                     {{(APB_DATA_W - ID_W){1'b0}}, id_offset_r} : '0;

  always_comb begin
    id_offset_nxt = id_offset_r;
    if (psel && penable && pwrite && pready && (reg_index == REG_ID_OFFSET)) begin
      id_offset_nxt = pwdata[ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_offset_r <= '0;
    end else begin
      id_offset_r <= id_offset_nxt;
    end
  end

  // Front end: match the identifier and queue the frame together with its message kind.
  cfu_front u_front (
    .in_ch      (in_ch),
    .id_offset  (id_offset_r),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  cfu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  // Back end: walk the fields of the frame at the queue head, one word per cycle unless out_ch stalls.
  cfu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/cfu_checker.sv
`default_nettype none

module cfu_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cfu_pkg::SLOT_W-1:0]  out_slot,
  input wire logic [cfu_pkg::FIELD_W-1:0] out_field,
  input wire logic                        out_last
);
  import cfu_pkg::*;

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled word keeps its framing.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_field)
                                && $stable(out_last))
    else $error("stalled output word changed");

  // Once a non-final word is taken, the next field of the same frame follows at once.
  a_next_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && (out_slot == $past(out_slot))
                                            && (out_field == $past(out_field) + 1'b1))
    else $error("field sequence broken");

  // Field numbers stay in range and the highest one always closes the frame.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field <= FIELD_MAX) && (out_slot <= SLOT_RESPONSE)
                  && ((out_field != FIELD_MAX) || out_last))
    else $error("field or slot out of range");

endmodule

bind can_frame_signal_unpacker cfu_checker u_cfu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_slot  (out_ch.message_slot),
  .out_field (out_ch.field_number),
  .out_last  (out_ch.last_field)
);

`default_nettype wire

FILE: tb/can_frame_signal_unpacker_tb.sv
`timescale 1ns / 1ps

module can_frame_signal_unpacker_tb;
  import cfu_pkg::*;

  // Long receiver hold-off, in cycles. With a queue only two frames deep, the block
  // has to stall its input well before this runs out.
  localparam int HOLD_CYCLES    = 300;
  // Cycles allowed after the last expected word. Frames with an unknown identifier make
  // no word but still have to be taken at the input.
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  // Frames in each random phase, whether they match a slot or not.
  localparam int RANDOM_FRAMES  = 58;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ID_OFFSET = {REG_ID_OFFSET, 2'b00};
  // Register index one past the only register. Writes there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED  = {~REG_ID_OFFSET, 2'b00};
  localparam logic [ID_W-1:0]       ID_MAX         = '1;
  // Highest offset at which the response slot still fits, landing on ID_MAX.
  localparam logic [ID_W-1:0]       OFFSET_TOP     = ID_MAX - REL_ID_RESPONSE;

  typedef enum int {PAT_ZERO, PAT_ONES, PAT_COUNT, PAT_RANDOM} data_pattern_t;

  typedef struct {
    logic [ID_W-1:0] id;
    frame_data_t     data;
  } can_frame_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] field;
    logic [VALUE_W-1:0] value;
    logic               last;
  } signal_t;

  typedef logic [VALUE_W-1:0] value_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cfu_in_if  in_ch ();
  cfu_out_if out_ch ();

  can_frame_signal_unpacker i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Frames waiting to be offered, and decoded signals waiting to come out, oldest first.
  can_frame_t pending_frames[$];
  signal_t    expected_signals[$];

  // Our copy of the offset register. It only changes while the block is idle.
  logic [ID_W-1:0] id_offset_shadow = '0;

  // Idle rates in percent for each side, changed from phase to phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus process bumps hold_requests; the receiver notices the change and
  // counts the hold-off down by itself.
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int error_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Relative identifier of a slot: dense from zero up to the last dense slot, then
  // the response slot sits on its own further up.
  function automatic int rel_id_of(int s);
    return (s == SLOT_RESPONSE) ? int'(REL_ID_RESPONSE) : s;
  endfunction

  // The sum is done in full integer width on purpose. A slot whose identifier would
  // pass the top of the 11-bit range must not wrap around to a low identifier.
  function automatic int match_slot(logic [ID_W-1:0] frame_id, logic [ID_W-1:0] base);
    int hit;
    hit = -1;
    for (int s = 0; s <= SLOT_RESPONSE; s++) begin
      if (hit < 0 && int'(base) + rel_id_of(s) == int'(frame_id)) begin
        hit = s;
      end
    end
    return hit;
  endfunction

  // Signal values of one matched frame, in field order. Byte i of the frame is d[i].
  function automatic value_q_t unpack_signals(logic [SLOT_W-1:0] slot, frame_data_t d);
    value_q_t    vals;
    logic [31:0] w0;
    logic [31:0] w1;
    w0 = {d[3], d[2], d[1], d[0]};
    w1 = {d[7], d[6], d[5], d[4]};
    case (slot)
      SLOT_ANALOG: begin
        // Each little-endian word packs three 10-bit readings from bit 0 upward.
        for (int i = 0; i < 3; i++) vals.push_back((w0 >> (10 * i)) & 32'h3FF);
        for (int i = 0; i < 3; i++) vals.push_back((w1 >> (10 * i)) & 32'h3FF);
      end
      SLOT_STATUS: begin
        vals.push_back(32'({d[1], d[0]}));
        vals.push_back(32'(d[2]));
        vals.push_back(32'(d[3]));
        vals.push_back(32'(d[4][0]));
        vals.push_back(32'(d[4][7:5]));
        vals.push_back(32'(d[5]));
        vals.push_back(32'(d[6][0]));
        vals.push_back(32'(d[6][7]));
        vals.push_back(32'(d[7][0]));
        vals.push_back(32'(d[7][1]));
        vals.push_back(32'(d[7][2]));
      end
      SLOT_DIAG: begin
        // The diagnostic words are the only big-endian fields.
        vals.push_back({d[0], d[1], d[2], d[3]});
        vals.push_back({d[4], d[5], d[6], d[7]});
      end
      SLOT_BYTES: begin
        for (int i = 0; i < FRAME_BYTES; i++) vals.push_back(32'(d[i]));
      end
      SLOT_TIMER: begin
        vals.push_back(32'({d[1], d[0]}));
        vals.push_back(32'({d[3], d[2]}));
        vals.push_back(w1);
      end
      SLOT_RESPONSE: begin
        vals.push_back(32'({d[1], d[0]}));
        vals.push_back(32'(d[2]));
        vals.push_back(32'({d[5], d[4]}));
      end
      default: begin
        // Every other slot carries four little-endian 16-bit words.
        for (int i = 0; i < 4; i++) vals.push_back(32'({d[2 * i + 1], d[2 * i]}));
      end
    endcase
    return vals;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic frame_data_t pattern_data(data_pattern_t p);
    case (p)
      PAT_ZERO:  return '0;
      PAT_ONES:  return '1;
      // Byte i holds i+1, so any byte-order mistake shows in the value.
      PAT_COUNT: return 64'h0807060504030201;
      default:   return {$urandom, $urandom};
    endcase
  endfunction

  // Queues a frame addressed to slot s at the current offset. Where the sum passes
  // the top of the identifier range it is cut to 11 bits, which is exactly the
  // wrapped identifier that must not match.
  task automatic queue_slot(int s, data_pattern_t p);
    can_frame_t f;
    f.id   = ID_W'(int'(id_offset_shadow) + rel_id_of(s));
    f.data = pattern_data(p);
    pending_frames.push_back(f);
  endtask

  task automatic queue_id(logic [ID_W-1:0] id, data_pattern_t p);
    can_frame_t f;
    f.id   = id;
    f.data = pattern_data(p);
    pending_frames.push_back(f);
  endtask

  // Mostly frames aimed at a slot, the rest identifiers drawn from the whole range.
  // Data is random, now and then all zeros, all ones or the counting pattern.
  task automatic queue_random_frames(int frames_wanted);
    can_frame_t    f;
    data_pattern_t p;
    for (int n = 0; n < frames_wanted; n++) begin
      if ($urandom_range(99) < 80) begin
        f.id = ID_W'(int'(id_offset_shadow) + rel_id_of($urandom_range(SLOT_RESPONSE)));
      end else begin
        f.id = ID_W'($urandom);
      end
      p = ($urandom_range(9) < 2) ? data_pattern_t'($urandom_range(PAT_COUNT)) : PAT_RANDOM;
      f.data = pattern_data(p);
      pending_frames.push_back(f);
    end
  endtask

  // One APB transfer: setup cycle, then access until pready. A read is checked
  // against the offset we believe the block holds.
  task automatic reg_access(bit is_write, logic [CFG_ADDR_W-1:0] addr,
                            logic [ID_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[ID_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (is_write && addr == ADDR_ID_OFFSET) id_offset_shadow = value;
    if (!is_write) check_field("id_offset", APB_DATA_W'(id_offset_shadow), prdata);
  endtask

  // Waits until every queued frame has been taken and every expected word has come
  // out, then adds the settling margin before returning.
  // Sampling on the falling edge keeps this clear of the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_frames.size() != 0 || in_ch.valid || expected_signals.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Frame driver: offers the queued frames and predicts the words of each frame at
  // the edge where it is taken, using the offset in force at that time.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : frame_driver
    int          slot_hit;
    value_q_t    vals;
    can_frame_t  f;
    frame_data_t d;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        d = {in_ch.byte7, in_ch.byte6, in_ch.byte5, in_ch.byte4,
             in_ch.byte3, in_ch.byte2, in_ch.byte1, in_ch.byte0};
        slot_hit = match_slot(in_ch.frame_id, id_offset_shadow);
        if (slot_hit >= 0) begin
          vals = unpack_signals(SLOT_W'(slot_hit), d);
          foreach (vals[k]) begin
            expected_signals.push_back('{SLOT_W'(slot_hit), FIELD_W'(k), vals[k],
                                         k == vals.size() - 1});
          end
        end
      end
      // A new frame may go out only once the current one is gone; valid is assigned
      // once per edge, so a frame that follows straight on keeps it high.
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          f = pending_frames.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.frame_id <= f.id;
          in_ch.byte0    <= f.data[0];
          in_ch.byte1    <= f.data[1];
          in_ch.byte2    <= f.data[2];
          in_ch.byte3    <= f.data[3];
          in_ch.byte4    <= f.data[4];
          in_ch.byte5    <= f.data[5];
          in_ch.byte6    <= f.data[6];
          in_ch.byte7    <= f.data[7];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random gaps, plus the long hold-off when asked for.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen    <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every word taken from the block is compared with the oldest expected word.
  always @(posedge clk) begin : result_monitor
    signal_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_signals.size() == 0) begin
        $error("word with nothing expected: slot %0d field %0d value 0x%0h last %0b",
               out_ch.message_slot, out_ch.field_number, out_ch.signal_value,
               out_ch.last_field);
        error_count++;
      end else begin
        want = expected_signals.pop_front();
        check_field("message_slot", 32'(want.slot), 32'(out_ch.message_slot));
        check_field("field_number", 32'(want.field), 32'(out_ch.field_number));
        check_field("signal_value", want.value, out_ch.signal_value);
        check_field("last_field", 32'(want.last), 32'(out_ch.last_field));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    data_pattern_t p;

    // Every block input gets a known value before the first edge.
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.frame_id = '0;
    in_ch.byte0    = '0;
    in_ch.byte1    = '0;
    in_ch.byte2    = '0;
    in_ch.byte3    = '0;
    in_ch.byte4    = '0;
    in_ch.byte5    = '0;
    in_ch.byte6    = '0;
    in_ch.byte7    = '0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    // First idle mix: sender idles now and then, receiver most of the time.
    send_idle_pct = 33;
    recv_idle_pct = 68;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The offset must come out of reset as zero.
    reg_access(1'b0, ADDR_ID_OFFSET, '0);

    // At offset zero, one frame per slot. The analog and status frames are all ones
    // so every packed field is at its top value; the diagnostic frame uses distinct
    // bytes to pin down the big-endian order. The rest cycle through the patterns.
    for (int s = 0; s <= SLOT_RESPONSE; s++) begin
      if (s == SLOT_DIAG) begin
        p = PAT_COUNT;
      end else if (s == SLOT_ANALOG || s == SLOT_STATUS) begin
        p = PAT_ONES;
      end else begin
        p = data_pattern_t'(s % 4);
      end
      queue_slot(s, p);
    end
    // Unknown identifiers: the gap right after the dense slots, and the top id.
    queue_id(ID_W'(REL_ID_LAST_DENSE) + 1'b1, PAT_ONES);
    queue_id(ID_MAX, PAT_RANDOM);
    wait_idle();

    // Highest offset that still reaches the response slot, which then lands on the
    // top identifier. Just below the offset nothing matches.
    reg_access(1'b1, ADDR_ID_OFFSET, OFFSET_TOP);
    reg_access(1'b0, ADDR_ID_OFFSET, '0);
    queue_slot(SLOT_RESPONSE, PAT_ONES);
    queue_slot(0, PAT_COUNT);
    queue_id(OFFSET_TOP - 1'b1, PAT_RANDOM);
    wait_idle();

    // A write to a register that does not exist must leave the offset alone.
    reg_access(1'b1, ADDR_UNMAPPED, ID_W'($urandom));
    reg_access(1'b0, ADDR_ID_OFFSET, '0);

    // Offset at the very top: only slot zero fits. Identifiers that the other slots
    // would reach if the sum wrapped must give nothing.
    reg_access(1'b1, ADDR_ID_OFFSET, ID_MAX);
    queue_id(ID_MAX, PAT_RANDOM);
    queue_slot(SLOT_RESPONSE, PAT_ONES);
    queue_slot(1, PAT_ONES);
    wait_idle();

    // Random phase at an offset where all slots are reachable.
    reg_access(1'b1, ADDR_ID_OFFSET, ID_W'($urandom_range(OFFSET_TOP)));
    queue_random_frames(RANDOM_FRAMES);
    wait_idle();

    // Second idle mix, the other way round, with offsets near the top so that part
    // of the slots can fall off the end of the identifier range.
    send_idle_pct = 68;
    recv_idle_pct = 33;
    reg_access(1'b1, ADDR_ID_OFFSET, ID_W'($urandom_range(ID_MAX, OFFSET_TOP - 23)));
    queue_random_frames(RANDOM_FRAMES);
    wait_idle();

    // Neither side idles. Once the frames are queued the receiver holds off for a
    // long stretch while the sender keeps offering, so the block fills and stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_access(1'b1, ADDR_ID_OFFSET, ID_W'($urandom_range(OFFSET_TOP)));
    queue_random_frames(RANDOM_FRAMES);
    hold_requests++;
    wait_idle();

    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("can_frame_signal_unpacker_tb: clean");
    end else begin
      $display("can_frame_signal_unpacker_tb: errors");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("can_frame_signal_unpacker_tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfu_pkg.sv
rtl/cfu_if.sv
rtl/cfu_front.sv
rtl/cfu_fifo.sv
rtl/cfu_back.sv
rtl/can_frame_signal_unpacker.sv
rtl/cfu_checker.sv
tb/can_frame_signal_unpacker_tb.sv
